>>> src/cht_pkg.sv
// Package with the types and constants of the chained hash table.
package cht_pkg;

    localparam int Buckets     = 16;
    localparam int PoolEntries = 64;
    localparam int BktW        = $clog2(Buckets);
    localparam int IdxW        = $clog2(PoolEntries);
    localparam int PtrW        = IdxW + 1;
    localparam int CntW        = 7;

    localparam logic [PtrW-1:0] Nil = PtrW'(PoolEntries);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_CHECK,
        S_UNLINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] name_handle;
        logic [31:0] disk_handle;
        logic [30:0] total_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_name;
        logic [31:0] found_disk;
        logic [30:0] found_size;
        logic [6:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] name;
        logic [31:0] disk;
        logic [30:0] size;
    } t_payload;

endpackage

>>> src/chained_hash_table.sv
// Top level of the chained hash table: chain walker over entry memories.
//
// The block keeps up to 64 transfer records in 16 bucket chains; the bucket is
// the low four bits of the key. Insert links a new record at the head of its
// chain, so the newest record for a key is found first. Remove unlinks the
// first match and lookup returns its fields. Each request reads the bucket
// head, then for each chain link visited does a synchronous memory read
// and then the key compare, and at last presents the response. After
// reset the block clears the bucket heads before it takes its first request.
// One response register parts the two sides; a new request is taken once
// the previous response has been delivered.
module chained_hash_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cht_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output cht_pkg::t_rsp o_rsp
);
    import cht_pkg::*;

    // Memories.
    logic [PtrW-1:0]  m_head [Buckets];
    logic [31:0]      m_key  [PoolEntries];
    logic [PtrW-1:0]  m_next [PoolEntries];
    t_payload         m_pay  [PoolEntries];
    logic [IdxW-1:0]  m_free [PoolEntries];

    t_state r_state, n_state;
    t_req   r_req;
    logic [BktW-1:0] r_clr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] r_cur, r_prev;
    logic [IdxW:0]   r_steps;
    logic [31:0]     r_rd_key;
    logic [PtrW-1:0] r_rd_next, r_rd_head;
    t_payload        r_rd_pay;
    logic [IdxW-1:0] r_rd_free;
    logic            r_ovalid;
    t_rsp            r_rsp;

    // Free stack starts as the identity: a fill count covers it, entries below
    // the low-water mark of written positions still read as their own index.
    logic [IdxW:0]   r_fill;

    logic accept, hit, full;
    logic [BktW-1:0] bkt;
    logic [IdxW-1:0] top;
    logic [IdxW-1:0] free_idx;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
    assign bkt     = r_req.key[BktW-1:0];
    assign full    = r_count >= CntW'(PoolEntries);
    assign top     = IdxW'(CntW'(PoolEntries) - r_count - CntW'(1));
    assign hit     = (r_rd_key == r_req.key);
    assign free_idx = ({1'b0, top} < r_fill) ? top : r_rd_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == BktW'(Buckets - 1)) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_HEAD;
            S_HEAD: begin
                if (t_action'(r_req.action) == ACT_INSERT
                        || t_action'(r_req.action) == ACT_NONE) begin
                    n_state = S_DONE;
                end else if (r_rd_head == Nil) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK:   n_state = S_CHECK;
            S_CHECK: begin
                if (hit) begin
                    n_state = (t_action'(r_req.action) == ACT_REMOVE) ? S_UNLINK : S_DONE;
                end else if (r_rd_next == Nil
                        || r_steps == (IdxW+1)'(PoolEntries - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_UNLINK: n_state = S_IDLE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory reads, registered.
    always_ff @(posedge i_clk) begin
        r_rd_head <= m_head[accept ? i_req.key[BktW-1:0] : bkt];
        r_rd_free <= m_free[top];
        r_rd_key  <= m_key[r_cur[IdxW-1:0]];
        r_rd_next <= m_next[r_cur[IdxW-1:0]];
        r_rd_pay  <= m_pay[r_cur[IdxW-1:0]];
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            m_head[r_clr] <= Nil;
        end
        if (r_state == S_HEAD && t_action'(r_req.action) == ACT_INSERT && !full) begin
            m_key[free_idx]  <= r_req.key;
            m_next[free_idx] <= r_rd_head;
            m_pay[free_idx]  <= '{r_req.name_handle, r_req.disk_handle, r_req.total_size};
            m_head[bkt]      <= {1'b0, free_idx};
        end
        if (r_state == S_UNLINK) begin
            if (r_prev == Nil) begin
                m_head[bkt] <= r_rd_next;
            end else begin
                m_next[r_prev[IdxW-1:0]] <= r_rd_next;
            end
            // The count has already dropped, so this is the slot of the new top.
            m_free[IdxW'(CntW'(PoolEntries) - r_count - CntW'(1))] <= r_cur[IdxW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
        if (r_state == S_HEAD) begin
            r_cur  <= r_rd_head;
            r_prev <= Nil;
            r_steps <= '0;
        end
        if (r_state == S_CHECK && !hit) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_next;
            r_steps <= r_steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_fill   <= (IdxW+1)'(PoolEntries);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_HEAD && t_action'(r_req.action) == ACT_INSERT) begin
                r_ovalid <= 1'b1;
                r_rsp    <= '{full ? ST_FULL : ST_OK, 32'd0, 32'd0, 31'd0,
                              full ? r_count : r_count + 1'b1};
                if (!full) r_count <= r_count + 1'b1;
            end
            if ((r_state == S_HEAD && t_action'(r_req.action) != ACT_INSERT
                    && (t_action'(r_req.action) == ACT_NONE || r_rd_head == Nil))
                    || (r_state == S_CHECK && !hit && (r_rd_next == Nil
                    || r_steps == (IdxW+1)'(PoolEntries - 1)))) begin
                r_ovalid <= 1'b1;
                r_rsp <= '{(t_action'(r_req.action) == ACT_NONE) ? ST_OK : ST_NOT_FOUND,
                           32'd0, 32'd0, 31'd0, r_count};
            end
            if (r_state == S_CHECK && hit) begin
                r_ovalid <= 1'b1;
                if (t_action'(r_req.action) == ACT_REMOVE) begin
                    r_rsp   <= '{ST_OK, 32'd0, 32'd0, 31'd0, r_count - 1'b1};
                    r_count <= r_count - 1'b1;
                end else begin
                    r_rsp <= '{ST_OK, r_rd_pay.name, r_rd_pay.disk, r_rd_pay.size, r_count};
                end
            end
            if (r_state == S_UNLINK
                    && (IdxW+1)'(CntW'(PoolEntries) - r_count - CntW'(1)) < r_fill) begin
                r_fill <= (IdxW+1)'(CntW'(PoolEntries) - r_count - CntW'(1));
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(PoolEntries)) else $error("record count above pool size");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while response pending");
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp)) else $error("response dropped");
endmodule
